@@ sv/stt_pkg.sv @@
`timescale 1ns / 1ps
package stt_pkg;

    localparam int MAX_REC = 4;
    localparam int Q_DEPTH = 2;
    localparam logic [19:0] LINE_MAX = 20'hFFFFF;

    localparam logic [1:0] RT_TEXT  = 2'd0;
    localparam logic [1:0] RT_TOKEN = 2'd1;
    localparam logic [1:0] RT_ERROR = 2'd2;

    typedef struct packed {
        logic [1:0]  rec_type;
        logic [4:0]  kind;
        logic [7:0]  chr;
        logic [5:0]  len;
        logic        trunc;
        logic [19:0] line;
        logic        last;
    } t_rec;

    typedef struct packed {
        t_rec [MAX_REC-1:0] recs;
        logic [2:0]         n;
    } t_bundle;

endpackage

@@ sv/stt_front.sv @@
`timescale 1ns / 1ps
module stt_front
    import stt_pkg::*;
#(
    parameter int MAX_TEXT = 63
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_ready,
    input  logic [7:0]   i_char,
    input  logic         i_last,
    output logic         o_push,
    output t_bundle      o_bundle
);

    localparam int CW = $clog2(MAX_TEXT + 1);

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_COMMENT = 3'd1;
    localparam logic [2:0] M_IDENT   = 3'd2;
    localparam logic [2:0] M_NUMBER  = 3'd3;
    localparam logic [2:0] M_STRING  = 3'd4;
    localparam logic [2:0] M_PENDOP  = 3'd5;
    localparam logic [2:0] M_HALTED  = 3'd6;

    localparam logic [4:0] K_END    = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_NUMBER = 5'd2;
    localparam logic [4:0] K_STRING = 5'd3;
    localparam logic [4:0] K_VAR    = 5'd4;
    localparam logic [4:0] K_FUNC   = 5'd5;
    localparam logic [4:0] K_IF     = 5'd6;
    localparam logic [4:0] K_ELIF   = 5'd7;
    localparam logic [4:0] K_ELSE   = 5'd8;
    localparam logic [4:0] K_OUT    = 5'd9;
    localparam logic [4:0] K_IN     = 5'd10;
    localparam logic [4:0] K_LPAREN = 5'd11;
    localparam logic [4:0] K_RPAREN = 5'd12;
    localparam logic [4:0] K_LBRACE = 5'd13;
    localparam logic [4:0] K_RBRACE = 5'd14;
    localparam logic [4:0] K_COMMA  = 5'd15;
    localparam logic [4:0] K_SEMI   = 5'd16;
    localparam logic [4:0] K_ASSIGN = 5'd17;
    localparam logic [4:0] K_PLUS   = 5'd18;
    localparam logic [4:0] K_MINUS  = 5'd19;
    localparam logic [4:0] K_STAR   = 5'd20;
    localparam logic [4:0] K_SLASH  = 5'd21;
    localparam logic [4:0] K_EQ     = 5'd22;
    localparam logic [4:0] K_NE     = 5'd23;
    localparam logic [4:0] K_GT     = 5'd24;
    localparam logic [4:0] K_LT     = 5'd25;
    localparam logic [4:0] K_GE     = 5'd26;
    localparam logic [4:0] K_LE     = 5'd27;
    localparam logic [4:0] K_NOT    = 5'd28;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [1:0] OP_EQ = 2'd0;
    localparam logic [1:0] OP_NE = 2'd1;
    localparam logic [1:0] OP_GT = 2'd2;
    localparam logic [1:0] OP_LT = 2'd3;

    localparam logic [39:0] KW_VAR  = 40'h0000766172;
    localparam logic [39:0] KW_FUNC = 40'h0066756E63;
    localparam logic [39:0] KW_IF   = 40'h0000006966;
    localparam logic [39:0] KW_ELIF = 40'h00656C6966;
    localparam logic [39:0] KW_ELSE = 40'h00656C7365;
    localparam logic [39:0] KW_OUT  = 40'h00006F7574;
    localparam logic [39:0] KW_IN   = 40'h000000696E;

    logic [2:0]    r_mode, n_mode;
    logic [1:0]    r_pend, n_pend;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [39:0]   r_pre, n_pre;
    logic [19:0]   r_line, n_line;
    logic          r_ovf, n_ovf;

    t_rec [MAX_REC-1:0] recs;
    logic [2:0]    nrec;

    function automatic logic [4:0] kw_kind(input logic [39:0] pre, input logic [CW-1:0] cnt,
                                           input logic ovf);
        logic [4:0] k;
        k = K_IDENT;
        if (!ovf) begin
            if (cnt == CW'(3) && pre == KW_VAR) k = K_VAR;
            else if (cnt == CW'(4) && pre == KW_FUNC) k = K_FUNC;
            else if (cnt == CW'(2) && pre == KW_IF) k = K_IF;
            else if (cnt == CW'(4) && pre == KW_ELIF) k = K_ELIF;
            else if (cnt == CW'(4) && pre == KW_ELSE) k = K_ELSE;
            else if (cnt == CW'(3) && pre == KW_OUT) k = K_OUT;
            else if (cnt == CW'(2) && pre == KW_IN) k = K_IN;
        end
        return k;
    endfunction

    function automatic logic [4:0] op_single(input logic [1:0] op);
        logic [4:0] k;
        case (op)
            OP_EQ:   k = K_ASSIGN;
            OP_NE:   k = K_NOT;
            OP_GT:   k = K_GT;
            default: k = K_LT;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] op_double(input logic [1:0] op);
        logic [4:0] k;
        case (op)
            OP_EQ:   k = K_EQ;
            OP_NE:   k = K_NE;
            OP_GT:   k = K_GE;
            default: k = K_LE;
        endcase
        return k;
    endfunction

    function automatic t_rec mk(input logic [1:0] rt, input logic [4:0] kind,
                                input logic [7:0] chr, input logic [5:0] len,
                                input logic trunc, input logic [19:0] line);
        t_rec r;
        r.rec_type = rt;
        r.kind     = kind;
        r.chr      = chr;
        r.len      = len;
        r.trunc    = trunc;
        r.line     = line;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic logic [19:0] line_inc(input logic [19:0] l);
        return (l < LINE_MAX) ? l + 20'd1 : l;
    endfunction

    always_comb begin
        logic       go_idle;
        logic       do_app;
        logic [4:0] cls;
        logic [7:0] c;
        logic       is_dig;
        logic       is_alp;
        logic       is_sp;
        c       = i_char;
        is_dig  = (c >= CH_0) && (c <= CH_9);
        is_alp  = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
        is_sp   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_pre   = r_pre;
        n_ovf   = r_ovf;
        n_line  = r_line;
        nrec    = 3'd0;
        recs    = '0;
        go_idle = 1'b0;
        do_app  = 1'b0;
        cls     = K_IDENT;

        case (r_mode)
            M_HALTED: begin
            end
            M_COMMENT: begin
                if (c == CH_LF) begin
                    n_mode = M_IDLE;
                    n_line = line_inc(n_line);
                end
            end
            M_STRING: begin
                if (c == CH_QUOTE) begin
                    recs[nrec[1:0]] = mk(RT_TOKEN, K_STRING, 8'd0, 6'(n_cnt), n_ovf, n_line);
                    nrec   = nrec + 3'd1;
                    n_mode = M_IDLE;
                    n_cnt  = '0;
                    n_pre  = '0;
                    n_ovf  = 1'b0;
                end else begin
                    do_app = 1'b1;
                    cls    = K_STRING;
                end
            end
            M_PENDOP: begin
                n_mode = M_IDLE;
                if (c == CH_EQ) begin
                    recs[nrec[1:0]] = mk(RT_TOKEN, op_double(r_pend), 8'd0, 6'd0, 1'b0, n_line);
                    nrec = nrec + 3'd1;
                end else begin
                    recs[nrec[1:0]] = mk(RT_TOKEN, op_single(r_pend), 8'd0, 6'd0, 1'b0, n_line);
                    nrec    = nrec + 3'd1;
                    go_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alp || is_dig || c == CH_UNDER) begin
                    do_app = 1'b1;
                    cls    = K_IDENT;
                end else begin
                    recs[nrec[1:0]] = mk(RT_TOKEN, kw_kind(r_pre, r_cnt, r_ovf), 8'd0,
                                         6'(r_cnt), r_ovf, n_line);
                    nrec    = nrec + 3'd1;
                    go_idle = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_dig) begin
                    do_app = 1'b1;
                    cls    = K_NUMBER;
                end else begin
                    recs[nrec[1:0]] = mk(RT_TOKEN, K_NUMBER, 8'd0, 6'(r_cnt), r_ovf, n_line);
                    nrec    = nrec + 3'd1;
                    go_idle = 1'b1;
                end
            end
            default: begin
                go_idle = 1'b1;
            end
        endcase

        if (go_idle) begin
            n_mode = M_IDLE;
            n_cnt  = '0;
            n_pre  = '0;
            n_ovf  = 1'b0;
            case (c)
                CH_EQ:    begin n_pend = OP_EQ; n_mode = M_PENDOP; end
                CH_BANG:  begin n_pend = OP_NE; n_mode = M_PENDOP; end
                CH_GT:    begin n_pend = OP_GT; n_mode = M_PENDOP; end
                CH_LT:    begin n_pend = OP_LT; n_mode = M_PENDOP; end
                CH_COLON: n_mode = M_COMMENT;
                CH_QUOTE: n_mode = M_STRING;
                CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_SEMI,
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                    case (c)
                        CH_LPAREN: recs[nrec[1:0]] = mk(RT_TOKEN, K_LPAREN, 8'd0, 6'd0, 1'b0, n_line);
                        CH_RPAREN: recs[nrec[1:0]] = mk(RT_TOKEN, K_RPAREN, 8'd0, 6'd0, 1'b0, n_line);
                        CH_LBRACE: recs[nrec[1:0]] = mk(RT_TOKEN, K_LBRACE, 8'd0, 6'd0, 1'b0, n_line);
                        CH_RBRACE: recs[nrec[1:0]] = mk(RT_TOKEN, K_RBRACE, 8'd0, 6'd0, 1'b0, n_line);
                        CH_COMMA:  recs[nrec[1:0]] = mk(RT_TOKEN, K_COMMA, 8'd0, 6'd0, 1'b0, n_line);
                        CH_SEMI:   recs[nrec[1:0]] = mk(RT_TOKEN, K_SEMI, 8'd0, 6'd0, 1'b0, n_line);
                        CH_PLUS:   recs[nrec[1:0]] = mk(RT_TOKEN, K_PLUS, 8'd0, 6'd0, 1'b0, n_line);
                        CH_MINUS:  recs[nrec[1:0]] = mk(RT_TOKEN, K_MINUS, 8'd0, 6'd0, 1'b0, n_line);
                        CH_STAR:   recs[nrec[1:0]] = mk(RT_TOKEN, K_STAR, 8'd0, 6'd0, 1'b0, n_line);
                        default:   recs[nrec[1:0]] = mk(RT_TOKEN, K_SLASH, 8'd0, 6'd0, 1'b0, n_line);
                    endcase
                    nrec = nrec + 3'd1;
                end
                default: begin
                    if (is_sp) begin
                        if (c == CH_LF) n_line = line_inc(n_line);
                    end else if (is_dig) begin
                        n_mode = M_NUMBER;
                        do_app = 1'b1;
                        cls    = K_NUMBER;
                    end else if (is_alp) begin
                        n_mode = M_IDENT;
                        do_app = 1'b1;
                        cls    = K_IDENT;
                    end else begin
                        recs[nrec[1:0]] = mk(RT_ERROR, K_END, c, 6'd0, 1'b0, n_line);
                        nrec   = nrec + 3'd1;
                        n_mode = M_HALTED;
                    end
                end
            endcase
        end

        if (do_app) begin
            if (n_cnt < CW'(MAX_TEXT)) begin
                if (n_cnt < CW'(5)) n_pre = {n_pre[31:0], c};
                n_cnt = n_cnt + CW'(1);
                recs[nrec[1:0]] = mk(RT_TEXT, cls, c, 6'(n_cnt), 1'b0, n_line);
                nrec = nrec + 3'd1;
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (i_last) begin
            if (n_mode != M_HALTED) begin
                case (n_mode)
                    M_PENDOP: begin
                        recs[nrec[1:0]] = mk(RT_TOKEN, op_single(n_pend), 8'd0, 6'd0, 1'b0,
                                             n_line);
                        nrec = nrec + 3'd1;
                    end
                    M_IDENT: begin
                        recs[nrec[1:0]] = mk(RT_TOKEN, kw_kind(n_pre, n_cnt, n_ovf), 8'd0,
                                             6'(n_cnt), n_ovf, n_line);
                        nrec = nrec + 3'd1;
                    end
                    M_NUMBER: begin
                        recs[nrec[1:0]] = mk(RT_TOKEN, K_NUMBER, 8'd0, 6'(n_cnt), n_ovf, n_line);
                        nrec = nrec + 3'd1;
                    end
                    M_STRING: begin
                        recs[nrec[1:0]] = mk(RT_TOKEN, K_STRING, 8'd0, 6'(n_cnt), n_ovf, n_line);
                        nrec = nrec + 3'd1;
                    end
                    default: begin
                    end
                endcase
                recs[nrec[1:0]] = mk(RT_TOKEN, K_END, 8'd0, 6'd0, 1'b0, n_line);
                nrec = nrec + 3'd1;
            end
            n_mode = M_IDLE;
            n_pend = OP_EQ;
            n_cnt  = '0;
            n_pre  = '0;
            n_ovf  = 1'b0;
            n_line = 20'd1;
        end

        if (nrec != 3'd0) recs[2'(nrec - 3'd1)].last = 1'b1;
    end

    assign o_bundle.recs = recs;
    assign o_bundle.n    = nrec;
    assign o_push        = i_valid && i_ready && (nrec != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pend <= OP_EQ;
            r_cnt  <= '0;
            r_pre  <= '0;
            r_line <= 20'd1;
            r_ovf  <= 1'b0;
        end else if (i_valid && i_ready) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
            r_pre  <= n_pre;
            r_line <= n_line;
            r_ovf  <= n_ovf;
        end
    end

endmodule

@@ sv/stt_queue.sv @@
`timescale 1ns / 1ps
module stt_queue
    import stt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output logic    o_space,
    output logic    o_avail,
    output t_bundle o_head
);

    localparam int AW = $clog2(Q_DEPTH);

    t_bundle r_mem [Q_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_space = (r_cnt != (AW+1)'(Q_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(Q_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (i_pop)  r_rd <= (r_rd == AW'(Q_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + (AW+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (AW+1)'(1);
        end
    end

endmodule

@@ sv/stt_back.sv @@
`timescale 1ns / 1ps
module stt_back
    import stt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_avail,
    input  t_bundle     i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rec        o_rec
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_rec       r_rec;
    logic       load;
    logic       at_end;

    assign load    = i_avail && (!r_valid || i_ready);
    assign at_end  = ({1'b0, r_idx} == (i_head.n - 3'd1));
    assign o_pop   = load && at_end;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (load) r_rec <= i_head.recs[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

@@ sv/source_text_tokenizer.sv @@
`timescale 1ns / 1ps
// The first record of a byte is scanned combinationally into the queue when the byte
// is taken, then goes from the queue into the output register on the master side.
// Throughput: one byte per cycle while each byte gives at most one record and the
// master side is ready; a byte with more records holds the output side as they leave
// the one-record-per-cycle output register. A two-entry queue lets bytes arrive meanwhile.
// Reset: synchronous, active low; clears scan state, sets line to 1, empties the queue.
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int MAX_TEXT = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_char
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [4:0] token_kind, [12:5] text_char,
                                        // [18:13] text_length, [19] text_truncated,
                                        // [39:20] line_number
    output logic [1:0]  m_axis_tuser,   // [1:0] record_type
    output logic        m_axis_tlast
);

    logic    space, push, avail, pop;
    t_bundle bundle, head;
    t_rec    rec;

    assign s_axis_tready = space;

    stt_front #(
        .MAX_TEXT (MAX_TEXT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_ready  (space),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_bundle (bundle)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (bundle),
        .i_pop   (pop),
        .o_space (space),
        .o_avail (avail),
        .o_head  (head)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (rec)
    );

    assign m_axis_tdata = {rec.line, rec.trunc, rec.len, rec.chr, rec.kind};
    assign m_axis_tuser = rec.rec_type;
    assign m_axis_tlast = rec.last;

endmodule

@@ tb/source_text_tokenizer_test.sv @@
`timescale 1ns / 1ps
module source_text_tokenizer_test;
    import stt_pkg::*;

    localparam int MAX_TXT = 63;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam logic [7:0] CH_NL = 8'h0a;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_COMMENT, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_PENDOP, SCAN_HALTED
    } t_scan;

    typedef enum logic [4:0] {
        TK_END, TK_IDENT, TK_NUMBER, TK_STRING, TK_VAR, TK_FUNC, TK_IF, TK_ELIF, TK_ELSE,
        TK_OUT, TK_IN, TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_COMMA, TK_SEMI,
        TK_ASSIGN, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_EQ, TK_NE, TK_GT, TK_LT,
        TK_GE, TK_LE, TK_NOT
    } t_tok;

    typedef struct {
        logic [7:0] chr;
        logic       eot;
        logic       pause;
    } t_src_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] source_char
    logic        s_axis_tlast = 1'b0;  // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [4:0] token_kind, [12:5] text_char,
                                       // [18:13] text_length, [19] text_truncated,
                                       // [39:20] line_number
    logic [1:0]  m_axis_tuser;         // [1:0] record_type
    logic        m_axis_tlast;

    source_text_tokenizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    t_src_item src_q[$];
    t_rec      expected_recs[$];
    t_rec      byte_recs[$];
    int        errors = 0;
    int        bytes_sent = 0;
    int        records_seen = 0;
    int        hold_cnt = 0;
    bit        hold_done = 1'b0;
    int        stall_cycles = 0;

    // scanner state mirror
    t_scan       mode;
    t_tok        pend_op;
    logic [5:0]  txt_cnt;
    logic [39:0] kw_prefix;
    logic [19:0] line_no;
    logic        txt_over;

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void add_rec(logic [1:0] rtype, t_tok kind, logic [7:0] chr,
                                    logic [5:0] len, logic trunc);
        t_rec r;
        if (byte_recs.size() < MAX_REC) begin
            r.rec_type = rtype;
            r.kind     = kind;
            r.chr      = chr;
            r.len      = len;
            r.trunc    = trunc;
            r.line     = line_no;
            r.last     = 1'b0;
            byte_recs.push_back(r);
        end
    endfunction

    function automatic void start_text(t_scan m);
        mode      = m;
        txt_cnt   = '0;
        kw_prefix = '0;
        txt_over  = 1'b0;
    endfunction

    function automatic void reset_scanner();
        start_text(SCAN_IDLE);
        pend_op = TK_ASSIGN;
        line_no = 20'd1;
    endfunction

    function automatic void bump_line();
        if (line_no != LINE_MAX) begin
            line_no = line_no + 20'd1;
        end
    endfunction

    function automatic void take_char(t_tok cls, logic [7:0] c);
        if (txt_cnt < 6'(MAX_TXT)) begin
            if (txt_cnt < 6'd5) begin
                kw_prefix = {kw_prefix[31:0], c};
            end
            txt_cnt = txt_cnt + 6'd1;
            add_rec(RT_TEXT, cls, c, txt_cnt, 1'b0);
        end else begin
            txt_over = 1'b1;
        end
    endfunction

    function automatic void close_text(t_tok kind);
        add_rec(RT_TOKEN, kind, 8'h00, txt_cnt, txt_over);
        start_text(SCAN_IDLE);
    endfunction

    function automatic void close_ident();
        t_tok k;
        k = TK_IDENT;
        // prefix holds exactly txt_cnt bytes, upper bits zero
        if (!txt_over) begin
            case (txt_cnt)
                6'd2: begin
                    if (kw_prefix[15:0] == "if") k = TK_IF;
                    else if (kw_prefix[15:0] == "in") k = TK_IN;
                end
                6'd3: begin
                    if (kw_prefix[23:0] == "var") k = TK_VAR;
                    else if (kw_prefix[23:0] == "out") k = TK_OUT;
                end
                6'd4: begin
                    if (kw_prefix[31:0] == "func") k = TK_FUNC;
                    else if (kw_prefix[31:0] == "elif") k = TK_ELIF;
                    else if (kw_prefix[31:0] == "else") k = TK_ELSE;
                end
                default: ;
            endcase
        end
        close_text(k);
    endfunction

    function automatic void scan_idle(logic [7:0] c);
        case (c)
            "=": begin pend_op = TK_ASSIGN; mode = SCAN_PENDOP; end
            "!": begin pend_op = TK_NOT;    mode = SCAN_PENDOP; end
            ">": begin pend_op = TK_GT;     mode = SCAN_PENDOP; end
            "<": begin pend_op = TK_LT;     mode = SCAN_PENDOP; end
            " ", 8'h09, 8'h0b, 8'h0c, 8'h0d: ;
            CH_NL: bump_line();
            ":": mode = SCAN_COMMENT;
            "(": add_rec(RT_TOKEN, TK_LPAREN, 8'h00, 6'd0, 1'b0);
            ")": add_rec(RT_TOKEN, TK_RPAREN, 8'h00, 6'd0, 1'b0);
            "{": add_rec(RT_TOKEN, TK_LBRACE, 8'h00, 6'd0, 1'b0);
            "}": add_rec(RT_TOKEN, TK_RBRACE, 8'h00, 6'd0, 1'b0);
            ",": add_rec(RT_TOKEN, TK_COMMA, 8'h00, 6'd0, 1'b0);
            ";": add_rec(RT_TOKEN, TK_SEMI, 8'h00, 6'd0, 1'b0);
            "+": add_rec(RT_TOKEN, TK_PLUS, 8'h00, 6'd0, 1'b0);
            "-": add_rec(RT_TOKEN, TK_MINUS, 8'h00, 6'd0, 1'b0);
            "*": add_rec(RT_TOKEN, TK_STAR, 8'h00, 6'd0, 1'b0);
            "/": add_rec(RT_TOKEN, TK_SLASH, 8'h00, 6'd0, 1'b0);
            "\"": start_text(SCAN_STRING);
            default: begin
                if (is_digit(c)) begin
                    start_text(SCAN_NUMBER);
                    take_char(TK_NUMBER, c);
                end else if (is_alpha(c)) begin
                    start_text(SCAN_IDENT);
                    take_char(TK_IDENT, c);
                end else begin
                    add_rec(RT_ERROR, TK_END, c, 6'd0, 1'b0);
                    mode = SCAN_HALTED;
                end
            end
        endcase
    endfunction

    // expected records for one accepted byte, appended to expected_recs
    function automatic void predict_records(logic [7:0] c, logic eot);
        byte_recs.delete();
        case (mode)
            SCAN_HALTED: ;
            SCAN_COMMENT: begin
                if (c == CH_NL) begin
                    mode = SCAN_IDLE;
                    bump_line();
                end
            end
            SCAN_STRING: begin
                if (c == "\"") close_text(TK_STRING);
                else take_char(TK_STRING, c);
            end
            SCAN_PENDOP: begin
                mode = SCAN_IDLE;
                if (c == "=") begin
                    case (pend_op)
                        TK_ASSIGN: add_rec(RT_TOKEN, TK_EQ, 8'h00, 6'd0, 1'b0);
                        TK_NOT:    add_rec(RT_TOKEN, TK_NE, 8'h00, 6'd0, 1'b0);
                        TK_GT:     add_rec(RT_TOKEN, TK_GE, 8'h00, 6'd0, 1'b0);
                        default:   add_rec(RT_TOKEN, TK_LE, 8'h00, 6'd0, 1'b0);
                    endcase
                end else begin
                    add_rec(RT_TOKEN, pend_op, 8'h00, 6'd0, 1'b0);
                    scan_idle(c);
                end
            end
            SCAN_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    take_char(TK_IDENT, c);
                end else begin
                    close_ident();
                    scan_idle(c);
                end
            end
            SCAN_NUMBER: begin
                if (is_digit(c)) begin
                    take_char(TK_NUMBER, c);
                end else begin
                    close_text(TK_NUMBER);
                    scan_idle(c);
                end
            end
            default: scan_idle(c);
        endcase
        if (eot) begin
            if (mode != SCAN_HALTED) begin
                case (mode)
                    SCAN_PENDOP: add_rec(RT_TOKEN, pend_op, 8'h00, 6'd0, 1'b0);
                    SCAN_IDENT:  close_ident();
                    SCAN_NUMBER: close_text(TK_NUMBER);
                    SCAN_STRING: close_text(TK_STRING);
                    default: ;
                endcase
                add_rec(RT_TOKEN, TK_END, 8'h00, 6'd0, 1'b0);
            end
            reset_scanner();
        end
        if (byte_recs.size() != 0) begin
            byte_recs[byte_recs.size() - 1].last = 1'b1;
        end
        foreach (byte_recs[i]) begin
            expected_recs.push_back(byte_recs[i]);
        end
    endfunction

    // ---------------- stimulus ----------------
    task automatic push_bytes(logic [7:0] prog[$], bit pause_first);
        t_src_item item;
        foreach (prog[i]) begin
            item.chr   = prog[i];
            item.eot   = (i == prog.size() - 1);
            item.pause = pause_first && (i == 0);
            src_q.push_back(item);
        end
    endtask

    task automatic push_segment(string s);
        logic [7:0] prog[$];
        for (int i = 0; i < s.len(); i++) begin
            prog.push_back(s[i]);
        end
        push_bytes(prog, 1'b0);
    endtask

    function automatic logic [7:0] rand_alpha();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "a" : "A";
        return base + 8'($urandom_range(0, 25));
    endfunction

    task automatic add_program(bit long_ident, bit pause_first);
        string      kw_words[7];
        string      op_words[18];
        string      w;
        logic [7:0] prog[$];
        logic [7:0] b;
        int         n_tok;
        int         len;
        kw_words = '{"var", "func", "if", "elif", "else", "out", "in"};
        op_words = '{"(", ")", "{", "}", ",", ";", "=", "+", "-", "*", "/",
                     "==", "!=", ">", "<", ">=", "<=", "!"};
        n_tok = $urandom_range(4, 14);
        for (int t = 0; t < n_tok; t++) begin
            case ((long_ident && t == 0) ? 1 : $urandom_range(0, 9))
                0: begin
                    w = kw_words[$urandom_range(0, 6)];
                    for (int i = 0; i < w.len(); i++) prog.push_back(w[i]);
                end
                1, 2: begin
                    if (long_ident && t == 0) len = 70;
                    else len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70)
                                                            : $urandom_range(1, 6);
                    prog.push_back(rand_alpha());
                    for (int i = 1; i < len; i++) begin
                        case ($urandom_range(0, 2))
                            0: prog.push_back(rand_alpha());
                            1: prog.push_back("0" + 8'($urandom_range(0, 9)));
                            default: prog.push_back("_");
                        endcase
                    end
                end
                3: begin
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++) prog.push_back("0" + 8'($urandom_range(0, 9)));
                end
                4: begin
                    len = ($urandom_range(0, 29) == 0) ? 66 : $urandom_range(0, 6);
                    prog.push_back("\"");
                    for (int i = 0; i < len; i++) begin
                        b = 8'($urandom_range(0, 255));
                        prog.push_back(b == "\"" ? "#" : b);
                    end
                    if (t != n_tok - 1 || $urandom_range(0, 1)) prog.push_back("\"");
                end
                5, 6: begin
                    w = op_words[$urandom_range(0, 17)];
                    for (int i = 0; i < w.len(); i++) prog.push_back(w[i]);
                end
                7: begin
                    case ($urandom_range(0, 5))
                        0: prog.push_back(8'h09);
                        1: prog.push_back(CH_NL);
                        2: prog.push_back(8'h0b);
                        3: prog.push_back(8'h0c);
                        4: prog.push_back(8'h0d);
                        default: prog.push_back(" ");
                    endcase
                end
                8: begin
                    prog.push_back(":");
                    len = $urandom_range(0, 5);
                    for (int i = 0; i < len; i++) begin
                        b = 8'($urandom_range(0, 255));
                        prog.push_back(b == CH_NL ? "x" : b);
                    end
                    prog.push_back(CH_NL);
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) prog.push_back(8'($urandom_range(0, 255)));
                    else prog.push_back(" ");
                end
            endcase
            if ($urandom_range(0, 1)) prog.push_back(" ");
        end
        push_bytes(prog, pause_first);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin : drive_src
        t_src_item item;
        bit        idle;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_records(s_axis_tdata, s_axis_tlast);
                bytes_sent <= bytes_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                idle = !(bytes_sent >= 150 && bytes_sent < 230) && hold_cnt == 0
                       && $urandom_range(0, 99) < 36;
                if (src_q.size() != 0 && !idle
                        && !(src_q[0].pause && expected_recs.size() != 0)) begin
                    item = src_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.chr;
                    s_axis_tlast  <= item.eot;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ready ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt      <= hold_cnt - 1;
            m_axis_tready <= (hold_cnt == 1);
        end else if (!hold_done && records_seen >= 60) begin
            hold_done     <= 1'b1;
            hold_cnt      <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (records_seen >= 250 && records_seen < 400)
                             || $urandom_range(0, 99) >= 36;
        end
    end

    // ---------------- monitor ----------------
    task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch_records
        t_rec want;
        t_rec got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rec_type = m_axis_tuser;
            got.kind     = m_axis_tdata[4:0];
            got.chr      = m_axis_tdata[12:5];
            got.len      = m_axis_tdata[18:13];
            got.trunc    = m_axis_tdata[19];
            got.line     = m_axis_tdata[39:20];
            got.last     = m_axis_tlast;
            records_seen <= records_seen + 1;
            if (expected_recs.size() == 0) begin
                $display("%0t: unexpected record, expected none, actual %0h", $time, got);
                errors++;
            end else begin
                want = expected_recs.pop_front();
                check_field("record_type", 20'(want.rec_type), 20'(got.rec_type));
                check_field("token_kind", 20'(want.kind), 20'(got.kind));
                check_field("text_char", 20'(want.chr), 20'(got.chr));
                check_field("text_length", 20'(want.len), 20'(got.len));
                check_field("text_truncated", 20'(want.trunc), 20'(got.trunc));
                check_field("line_number", want.line, got.line);
                check_field("last_of_run", 20'(want.last), 20'(got.last));
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        logic [7:0] nul_byte[$];
        int         prog_idx;
        reset_scanner();

        push_segment("a<=b==c>");      // pending operator flushed at end of text
        push_segment("\"\377\n\"!");   // newline inside a string is not counted
        push_segment(":x\n7 ");        // comment to newline, number ended by space
        push_segment("_q");            // unexpected byte, then silence through the last byte
        nul_byte.push_back(8'h00);
        push_bytes(nul_byte, 1'b0);    // error on the final byte itself
        push_segment("in\n");          // keyword ended by newline keeps its line

        prog_idx = 0;
        while (src_q.size() < 310) begin
            add_program(prog_idx == 1, prog_idx == 3 || prog_idx == 8);
            prog_idx++;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (src_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_recs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ source_text_tokenizer.f @@
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/stt_back.sv
sv/source_text_tokenizer.sv
tb/source_text_tokenizer_test.sv
